// ----- rtl/msadpcm_pkg.sv -----
// msadpcm_pkg: shared types, constants and the step adaptation table of the
// block ADPCM decoder. No dependencies.
`default_nettype none

package msadpcm_pkg;

  localparam int unsigned MAX_CHANNELS = 2;
  localparam int unsigned CH_W         = 1;
  localparam int unsigned NUM_PREDICTORS = 7;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 64;
  localparam int unsigned HPOS_W       = 5;
  localparam logic [15:0] DELTA_FLOOR  = 16'd16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHANNEL_COUNT  = 3'd0,
    CFG_MAX_DATA_BYTES = 3'd1,
    CFG_COEF_PAIRS_0_1 = 3'd2,
    CFG_COEF_PAIRS_2_3 = 3'd3,
    CFG_COEF_PAIRS_4_5 = 3'd4,
    CFG_COEF_PAIR_6    = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]  channel_count;
    logic [15:0] max_data_bytes;
    logic [63:0] coef_pairs_0_1;
    logic [63:0] coef_pairs_2_3;
    logic [63:0] coef_pairs_4_5;
    logic [31:0] coef_pair_6;
  } cfg_t;

  typedef enum logic [2:0] {
    OP_COEF  = 3'd0,
    OP_DELTA = 3'd1,
    OP_HIST0 = 3'd2,
    OP_HIST1 = 3'd3,
    OP_BAD   = 3'd4,
    OP_DATA  = 3'd5
  } cmd_op_e;

  // ch carries the stereo flag on a data command
  typedef struct packed {
    cmd_op_e           op;
    logic [CH_W-1:0]   ch;
    logic [31:0]       data;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_MUL  = 2'd1,
    BK_PRED = 2'd2,
    BK_UPD  = 2'd3
  } back_state_e;

  function automatic logic [9:0] adapt_factor(input logic [3:0] nib);
    logic [9:0] f;
    case (nib) inside
      4'd4, 4'd12: f = 10'd307;
      4'd5, 4'd11: f = 10'd409;
      4'd6, 4'd10: f = 10'd512;
      4'd7, 4'd9:  f = 10'd614;
      4'd8:        f = 10'd768;
      default:     f = 10'd230;
    endcase
    return f;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/msadpcm_in_if.sv -----
// msadpcm_in_if: valid/ready channel carrying one block byte per transfer.
// Depends on msadpcm_pkg.
`default_nettype none

interface msadpcm_in_if;
  import msadpcm_pkg::*;

  logic       valid;
  logic       ready;
  logic [7:0] block_byte;
  logic       block_start;

  modport source (output valid, block_byte, block_start, input ready);
  modport sink   (input valid, block_byte, block_start, output ready);
endinterface

`default_nettype wire

// ----- rtl/msadpcm_out_if.sv -----
// msadpcm_out_if: valid/ready channel carrying one decoded sample per transfer.
// Depends on msadpcm_pkg.
`default_nettype none

interface msadpcm_out_if;
  import msadpcm_pkg::*;

  logic                  valid;
  logic                  ready;
  logic signed [15:0]    pcm_sample;
  logic [CH_W-1:0]       channel_id;
  logic                  bad_predictor;
  logic                  last_of_byte;

  modport source (output valid, pcm_sample, channel_id, bad_predictor, last_of_byte,
                  input ready);
  modport sink   (input valid, pcm_sample, channel_id, bad_predictor, last_of_byte,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/ms_adpcm_block_decoder.sv -----
// Block decoder for 4-bit ADPCM: holds the configuration registers and joins
// the byte front end, command queue and decode back end. Uses msadpcm_pkg.
//
// in_ch takes one block byte per transfer; block_start marks the first byte of
// a block. The header (7 bytes per channel) is parsed in the front end and
// gives no samples, except one bad_predictor result for an index of 7 or more,
// after which the block is skipped. Each data byte gives two samples on out_ch,
// high nibble first, the second flagged last_of_byte.
// A data byte is queued and popped by the idle back end; each nibble then
// passes the multiply, predict and update states into the output register.
// The back end takes no new byte until both nibbles are done, as it runs the
// multiply, divide-by-256 and update steps once per nibble. Header commands
// are applied while it is idle. A two-entry command queue lets the front end
// keep taking bytes while the back end works or the receiver stalls; when the
// receiver holds out_ch.ready low the back end waits with its result in the
// output register and in_ch.ready falls once the queue fills.
// Reset clears the block position, data count and all handshakes and loads
// the register reset values; a new block needs its header before data.
`default_nettype none

module ms_adpcm_block_decoder (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  msadpcm_in_if.sink                           in_ch,
  msadpcm_out_if.source                        out_ch,
  input  wire                                  cfg_we_i,
  input  wire [msadpcm_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire [msadpcm_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import msadpcm_pkg::*;

  cfg_t cfg_q;
  logic q_push, q_full, q_pop, q_valid;
  cmd_t q_cmd, q_head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.channel_count  <= 2'd1;
      cfg_q.max_data_bytes <= 16'd256;
      cfg_q.coef_pairs_0_1 <= '0;
      cfg_q.coef_pairs_2_3 <= '0;
      cfg_q.coef_pairs_4_5 <= '0;
      cfg_q.coef_pair_6    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CHANNEL_COUNT:  cfg_q.channel_count  <= cfg_data_i[1:0];
        CFG_MAX_DATA_BYTES: cfg_q.max_data_bytes <= cfg_data_i[15:0];
        CFG_COEF_PAIRS_0_1: cfg_q.coef_pairs_0_1 <= cfg_data_i;
        CFG_COEF_PAIRS_2_3: cfg_q.coef_pairs_2_3 <= cfg_data_i;
        CFG_COEF_PAIRS_4_5: cfg_q.coef_pairs_4_5 <= cfg_data_i;
        CFG_COEF_PAIR_6:    cfg_q.coef_pair_6    <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  msadpcm_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .in_ch    (in_ch),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_cmd_o  (q_cmd)
  );

  msadpcm_cmd_fifo u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (q_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .head_o     (q_head)
  );

  msadpcm_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_head_i  (q_head),
    .q_pop_o   (q_pop),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

// ----- rtl/msadpcm_front.sv -----
// msadpcm_front: accepts block bytes, tracks header position and data count,
// and turns each byte into a command for the decode back end. Uses msadpcm_pkg.
`default_nettype none

module msadpcm_front (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire msadpcm_pkg::cfg_t cfg_i,
  msadpcm_in_if.sink          in_ch,
  input  wire                 q_full_i,
  output logic                q_push_o,
  output msadpcm_pkg::cmd_t   q_cmd_o
);
  import msadpcm_pkg::*;

  logic [HPOS_W-1:0] hpos_q, hpos_d;
  logic [15:0]       cnt_q, cnt_d;
  logic              drop_q, drop_d;
  logic [7:0]        low_q, low_d;

  logic              accept;
  logic              stereo;
  logic [HPOS_W-1:0] hlen, nch, hpos, p;
  logic [15:0]       cnt;
  logic              drop;
  logic [1:0]        grp;
  logic [63:0]       coef_word;
  logic [7:0]        b;

  assign in_ch.ready = !q_full_i;
  assign accept      = in_ch.valid && !q_full_i;
  assign b           = in_ch.block_byte;

  assign stereo = (MAX_CHANNELS >= 2) && cfg_i.channel_count[1];
  assign nch    = stereo ? HPOS_W'(2) : HPOS_W'(1);
  assign hlen   = stereo ? HPOS_W'(14) : HPOS_W'(7);

  assign hpos = in_ch.block_start ? '0 : hpos_q;
  assign cnt  = in_ch.block_start ? '0 : cnt_q;
  assign drop = in_ch.block_start ? 1'b0 : drop_q;
  assign p    = hpos - nch;
  assign grp  = stereo ? p[3:2] : p[2:1];

  always_comb begin
    case (b[2:1])
      2'd0:    coef_word = cfg_i.coef_pairs_0_1;
      2'd1:    coef_word = cfg_i.coef_pairs_2_3;
      2'd2:    coef_word = cfg_i.coef_pairs_4_5;
      default: coef_word = {32'd0, cfg_i.coef_pair_6};
    endcase
  end

  always_comb begin
    hpos_d   = hpos_q;
    cnt_d    = cnt_q;
    drop_d   = drop_q;
    low_d    = low_q;
    q_push_o = 1'b0;
    q_cmd_o  = '{op: OP_DATA, ch: '0, data: 32'd0};
    if (accept) begin
      hpos_d = hpos;
      cnt_d  = cnt;
      drop_d = drop;
      if (!drop) begin
        if (hpos < hlen) begin
          hpos_d = hpos + HPOS_W'(1);
          if (hpos < nch) begin
            q_push_o = 1'b1;
            q_cmd_o.ch = hpos[CH_W-1:0];
            if (b >= 8'(NUM_PREDICTORS)) begin
              drop_d     = 1'b1;
              q_cmd_o.op = OP_BAD;
            end else begin
              q_cmd_o.op   = OP_COEF;
              q_cmd_o.data = b[0] ? coef_word[63:32] : coef_word[31:0];
            end
          end else if (!p[0]) begin
            low_d = b;
          end else begin
            q_push_o     = 1'b1;
            q_cmd_o.ch   = stereo ? p[1] : 1'b0;
            q_cmd_o.data = {16'd0, b, low_q};
            case (grp)
              2'd0:    q_cmd_o.op = OP_DELTA;
              2'd1:    q_cmd_o.op = OP_HIST0;
              default: q_cmd_o.op = OP_HIST1;
            endcase
          end
        end else if (cnt < cfg_i.max_data_bytes) begin
          cnt_d        = cnt + 16'd1;
          q_push_o     = 1'b1;
          q_cmd_o.op   = OP_DATA;
          q_cmd_o.ch   = stereo;
          q_cmd_o.data = {24'd0, b};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hpos_q <= '0;
      cnt_q  <= '0;
      drop_q <= 1'b0;
      low_q  <= '0;
    end else begin
      hpos_q <= hpos_d;
      cnt_q  <= cnt_d;
      drop_q <= drop_d;
      low_q  <= low_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/msadpcm_cmd_fifo.sv -----
// msadpcm_cmd_fifo: two-entry command queue between front and back end.
// Uses msadpcm_pkg for the command type.
`default_nettype none

module msadpcm_cmd_fifo (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_i,
  input  wire msadpcm_pkg::cmd_t push_cmd_i,
  output logic                full_o,
  input  wire                 pop_i,
  output logic                valid_o,
  output msadpcm_pkg::cmd_t   head_o
);
  import msadpcm_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d  = !wr_q;
      cnt_d = cnt_d + 2'd1;
    end
    if (pop_i) begin
      rd_d  = !rd_q;
      cnt_d = cnt_d - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/msadpcm_back.sv -----
// msadpcm_back: applies header commands to the per-channel predictor state and
// decodes data bytes nibble by nibble into the output register. Uses msadpcm_pkg.
`default_nettype none

module msadpcm_back (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 q_valid_i,
  input  wire msadpcm_pkg::cmd_t q_head_i,
  output logic                q_pop_o,
  msadpcm_out_if.source       out_ch
);
  import msadpcm_pkg::*;

  back_state_e state_q, state_d;

  logic signed [15:0] coef0_q [MAX_CHANNELS];
  logic signed [15:0] coef1_q [MAX_CHANNELS];
  logic        [15:0] delta_q [MAX_CHANNELS];
  logic signed [15:0] hist0_q [MAX_CHANNELS];
  logic signed [15:0] hist1_q [MAX_CHANNELS];

  logic [7:0]         byte_q;
  logic               stereo_q;
  logic               nsel_q;
  logic signed [31:0] prod0_q, prod1_q;
  logic signed [24:0] pred_q;

  logic                  out_valid_q;
  logic signed [15:0]    out_pcm_q;
  logic [CH_W-1:0]       out_ch_q;
  logic                  out_bad_q;
  logic                  out_last_q;

  logic               out_free;
  logic               emit_bad, emit_smp;
  logic [CH_W-1:0]    ch;
  logic [3:0]         nib;
  logic signed [32:0] sum, biased;
  logic signed [20:0] dsn;
  logic signed [25:0] v;
  logic signed [15:0] v_clip;
  logic [25:0]        adapt_prod;
  logic [15:0]        d_new;

  assign out_free = !out_valid_q || out_ch.ready;
  assign ch       = nsel_q ? stereo_q : 1'b0;
  assign nib      = nsel_q ? byte_q[3:0] : byte_q[7:4];

  // prediction divided by 256, truncated toward zero
  assign sum    = 33'(prod0_q) + 33'(prod1_q);
  assign biased = sum + (sum[32] ? 33'sd255 : 33'sd0);

  assign dsn = $signed({1'b0, delta_q[ch]}) * $signed(nib);
  assign v   = 26'(pred_q) + 26'(dsn);

  always_comb begin
    if (v < -26'sd32768) begin
      v_clip = -16'sd32768;
    end else if (v > 26'sd32767) begin
      v_clip = 16'sd32767;
    end else begin
      v_clip = v[15:0];
    end
  end

  assign adapt_prod = adapt_factor(nib) * delta_q[ch];
  assign d_new      = (adapt_prod[23:8] < DELTA_FLOOR) ? DELTA_FLOOR : adapt_prod[23:8];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (q_pop_o && q_head_i.op == OP_DATA) begin
          state_d = BK_MUL;
        end
      end
      BK_MUL:  state_d = BK_PRED;
      BK_PRED: state_d = BK_UPD;
      BK_UPD: begin
        if (out_free) begin
          state_d = nsel_q ? BK_IDLE : BK_MUL;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop_o  = 1'b0;
    emit_bad = 1'b0;
    emit_smp = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        q_pop_o  = q_valid_i && (q_head_i.op != OP_BAD || out_free);
        emit_bad = q_valid_i && q_head_i.op == OP_BAD && out_free;
      end
      BK_UPD:  emit_smp = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit_bad || emit_smp) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      case (q_head_i.op)
        OP_COEF: begin
          coef0_q[q_head_i.ch] <= q_head_i.data[15:0];
          coef1_q[q_head_i.ch] <= q_head_i.data[31:16];
        end
        OP_DELTA: delta_q[q_head_i.ch] <= q_head_i.data[15:0];
        OP_HIST0: hist0_q[q_head_i.ch] <= q_head_i.data[15:0];
        OP_HIST1: hist1_q[q_head_i.ch] <= q_head_i.data[15:0];
        OP_DATA: begin
          byte_q   <= q_head_i.data[7:0];
          stereo_q <= q_head_i.ch[0];
          nsel_q   <= 1'b0;
        end
        default: ;
      endcase
    end
    if (state_q == BK_MUL) begin
      prod0_q <= hist0_q[ch] * coef0_q[ch];
      prod1_q <= hist1_q[ch] * coef1_q[ch];
    end
    if (state_q == BK_PRED) begin
      pred_q <= biased[32:8];
    end
    if (emit_smp) begin
      hist1_q[ch] <= hist0_q[ch];
      hist0_q[ch] <= v_clip;
      delta_q[ch] <= d_new;
      nsel_q      <= 1'b1;
      out_pcm_q   <= v_clip;
      out_ch_q    <= ch;
      out_bad_q   <= 1'b0;
      out_last_q  <= nsel_q;
    end else if (emit_bad) begin
      out_pcm_q  <= '0;
      out_ch_q   <= q_head_i.ch;
      out_bad_q  <= 1'b1;
      out_last_q <= 1'b1;
    end
  end

  assign out_ch.valid         = out_valid_q;
  assign out_ch.pcm_sample    = out_pcm_q;
  assign out_ch.channel_id    = out_ch_q;
  assign out_ch.bad_predictor = out_bad_q;
  assign out_ch.last_of_byte  = out_last_q;

endmodule

`default_nettype wire
